// ===== sv/i2cram_pkg.sv =====
`timescale 1ns / 1ps

package i2cram_pkg;

	// Bus timing and program constants
	localparam logic [15:0] DELAY_RESET = 16'd256;
	localparam logic [15:0] DELAY_MIN   = 16'd1;
	localparam logic [3:0]  PROG_LEN_WR = 4'd8;
	localparam logic [3:0]  PROG_LEN_RD = 4'd12;
	localparam logic [2:0]  LAST_BIT    = 3'd7;
	localparam logic [7:0]  READ_FLAG   = 8'h01;

	// Block kinds of a transaction program
	typedef enum logic [2:0] {
		KIND_START,
		KIND_WBIT,
		KIND_WACK,
		KIND_RPRE,
		KIND_RBIT,
		KIND_RACK,
		KIND_STOP
	} i2cram_kind_t;

	// Single bus actions, one per tick (delay may span several)
	typedef enum logic [3:0] {
		OP_SCLH,
		OP_SCLL,
		OP_SDAH,
		OP_SDAL,
		OP_REL,
		OP_OUT,
		OP_BIT,
		OP_SAMP,
		OP_DLY
	} i2cram_op_t;

	// Byte loaded into the shifter when a byte-send block begins
	typedef enum logic [2:0] {
		SEL_NONE,
		SEL_ID,
		SEL_ADDR,
		SEL_DATA,
		SEL_IDR
	} i2cram_sel_t;

	typedef struct packed {
		i2cram_kind_t kind;
		i2cram_sel_t  sel;
	} i2cram_blk_t;

	typedef struct packed {
		logic       action;
		logic [7:0] device_id;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
	} i2cram_req_t;

	typedef struct packed {
		logic       cmd_valid;
		logic       action;
		logic [7:0] device_id;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} i2cram_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
	} i2cram_res_t;

	// Number of actions in a block
	function automatic logic [2:0] kind_len(input i2cram_kind_t k);
		logic [2:0] len;
		unique case (k)
			KIND_START: len = 3'd6;
			KIND_WBIT:  len = 3'd5;
			KIND_WACK:  len = 3'd7;
			KIND_RPRE:  len = 3'd1;
			KIND_RBIT:  len = 3'd5;
			KIND_RACK:  len = 3'd7;
			KIND_STOP:  len = 3'd7;
			default:    len = 3'd7;
		endcase
		return len;
	endfunction

	// Action at a position inside a block
	function automatic i2cram_op_t kind_op(input i2cram_kind_t k, input logic [2:0] i);
		i2cram_op_t op;
		op = OP_SCLH;
		unique case (k)
			KIND_START: begin
				unique case (i)
					3'd0:    op = OP_SCLH;
					3'd2:    op = OP_SDAH;
					3'd4:    op = OP_SDAL;
					3'd1, 3'd3, 3'd5: op = OP_DLY;
					default: op = OP_SCLH;
				endcase
			end
			KIND_WBIT: begin
				unique case (i)
					3'd0:    op = OP_SCLL;
					3'd1:    op = OP_DLY;
					3'd2:    op = OP_BIT;
					3'd3:    op = OP_SCLH;
					3'd4:    op = OP_DLY;
					default: op = OP_SCLH;
				endcase
			end
			KIND_WACK: begin
				unique case (i)
					3'd0:    op = OP_SCLL;
					3'd1:    op = OP_REL;
					3'd2:    op = OP_DLY;
					3'd3:    op = OP_SCLH;
					3'd4:    op = OP_DLY;
					3'd5:    op = OP_SCLL;
					3'd6:    op = OP_OUT;
					default: op = OP_SCLH;
				endcase
			end
			KIND_RPRE: begin
				op = (i == 3'd0) ? OP_REL : OP_SCLH;
			end
			KIND_RBIT: begin
				unique case (i)
					3'd0:    op = OP_SCLL;
					3'd1:    op = OP_DLY;
					3'd2:    op = OP_SCLH;
					3'd3:    op = OP_SAMP;
					3'd4:    op = OP_DLY;
					default: op = OP_SCLH;
				endcase
			end
			KIND_RACK: begin
				unique case (i)
					3'd0:    op = OP_SCLL;
					3'd1:    op = OP_OUT;
					3'd2:    op = OP_SDAH;
					3'd3:    op = OP_DLY;
					3'd4:    op = OP_SCLH;
					3'd5:    op = OP_DLY;
					3'd6:    op = OP_SCLL;
					default: op = OP_SCLH;
				endcase
			end
			KIND_STOP: begin
				unique case (i)
					3'd1:    op = OP_SDAL;
					3'd3:    op = OP_SCLH;
					3'd5:    op = OP_SDAH;
					3'd0, 3'd2, 3'd4, 3'd6: op = OP_DLY;
					default: op = OP_SCLH;
				endcase
			end
			default: op = OP_SCLH;
		endcase
		return op;
	endfunction

	// Block of the write or read program at a given index
	function automatic i2cram_blk_t prog_block(input logic is_read, input logic [3:0] idx);
		i2cram_blk_t b;
		if (is_read) begin
			unique case (idx)
				4'd0:    b = '{KIND_START, SEL_NONE};
				4'd1:    b = '{KIND_WBIT,  SEL_ID};
				4'd2:    b = '{KIND_WACK,  SEL_NONE};
				4'd3:    b = '{KIND_WBIT,  SEL_ADDR};
				4'd4:    b = '{KIND_WACK,  SEL_NONE};
				4'd5:    b = '{KIND_START, SEL_NONE};
				4'd6:    b = '{KIND_WBIT,  SEL_IDR};
				4'd7:    b = '{KIND_WACK,  SEL_NONE};
				4'd8:    b = '{KIND_RPRE,  SEL_NONE};
				4'd9:    b = '{KIND_RBIT,  SEL_NONE};
				4'd10:   b = '{KIND_RACK,  SEL_NONE};
				default: b = '{KIND_STOP,  SEL_NONE};
			endcase
		end else begin
			unique case (idx)
				4'd0:    b = '{KIND_START, SEL_NONE};
				4'd1:    b = '{KIND_WBIT,  SEL_ID};
				4'd2:    b = '{KIND_WACK,  SEL_NONE};
				4'd3:    b = '{KIND_WBIT,  SEL_ADDR};
				4'd4:    b = '{KIND_WACK,  SEL_NONE};
				4'd5:    b = '{KIND_WBIT,  SEL_DATA};
				4'd6:    b = '{KIND_WACK,  SEL_NONE};
				default: b = '{KIND_STOP,  SEL_NONE};
			endcase
		end
		return b;
	endfunction

endpackage

// ===== sv/i2cram_if.sv =====
`timescale 1ns / 1ps

// Command channel: one beat per bus tick
interface i2cram_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic       action;
	logic [7:0] device_id;
	logic [7:0] reg_addr;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (
		output valid, cmd_valid, action, device_id, reg_addr, write_data, sda_in,
		input  ready
	);
	modport sink (
		input  valid, cmd_valid, action, device_id, reg_addr, write_data, sda_in,
		output ready
	);
endinterface

// Result channel: pin levels and status after each tick
interface i2cram_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;

	modport source (
		output valid, scl_level, sda_level, sda_enable, busy_res, done_res, read_byte,
		input  ready
	);
	modport sink (
		input  valid, scl_level, sda_level, sda_enable, busy_res, done_res, read_byte,
		output ready
	);
endinterface

// Configuration write channel for the delay register
interface i2cram_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] delay_ticks;

	modport source (
		output valid, delay_ticks,
		input  ready
	);
	modport sink (
		input  valid, delay_ticks,
		output ready
	);
endinterface

// ===== sv/i2cram_seq.sv =====
`timescale 1ns / 1ps

module i2cram_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  i2cram_pkg::i2cram_item_t item,
	input  logic [15:0]          delay_ticks,
	output i2cram_pkg::i2cram_res_t  res
);
	import i2cram_pkg::*;

	// Sequencer state
	logic        busy_q, busy_n;
	logic [3:0]  blk_q, blk_n;
	logic [2:0]  op_q, op_n;
	logic [2:0]  bit_q, bit_n;
	logic [7:0]  shift_q, shift_n;
	logic [15:0] wait_q, wait_n;
	i2cram_req_t req_q, req_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic        en_q, en_n;
	logic [7:0]  hold_q, hold_n;

	i2cram_blk_t cur_blk;
	i2cram_blk_t nxt_blk;
	i2cram_op_t  cur_op;
	logic [2:0]  cur_len;
	logic [2:0]  op_idx;
	logic [3:0]  blk_inc;
	logic [3:0]  prog_len;
	logic [15:0] dly_eff;
	logic [16:0] wait_sum;
	logic        step_done;
	logic        done;

	assign dly_eff = (delay_ticks == '0) ? DELAY_MIN : delay_ticks;

	// Run one tick: latch a new command when idle, then perform one action
	always_comb begin
		busy_n    = busy_q;
		blk_n     = blk_q;
		op_n      = op_q;
		bit_n     = bit_q;
		shift_n   = shift_q;
		wait_n    = wait_q;
		req_n     = req_q;
		scl_n     = scl_q;
		sda_n     = sda_q;
		en_n      = en_q;
		hold_n    = hold_q;
		done      = 1'b0;
		step_done = 1'b1;
		nxt_blk   = '{KIND_STOP, SEL_NONE};

		if (!busy_q && item.cmd_valid) begin
			req_n  = '{item.action, item.device_id, item.reg_addr, item.write_data};
			busy_n = 1'b1;
			blk_n  = '0;
			op_n   = '0;
			bit_n  = '0;
			wait_n = '0;
		end

		cur_blk  = prog_block(req_n.action, blk_n);
		cur_len  = kind_len(cur_blk.kind);
		op_idx   = (op_n >= cur_len) ? 3'd0 : op_n;
		cur_op   = kind_op(cur_blk.kind, op_idx);
		wait_sum = {1'b0, wait_n} + 17'd1;
		blk_inc  = blk_n + 4'd1;
		prog_len = req_n.action ? PROG_LEN_RD : PROG_LEN_WR;

		if (busy_n) begin
			unique case (cur_op)
				OP_SCLH: scl_n = 1'b1;
				OP_SCLL: scl_n = 1'b0;
				OP_SDAH: sda_n = 1'b1;
				OP_SDAL: sda_n = 1'b0;
				OP_REL:  en_n  = 1'b0;
				OP_OUT:  en_n  = 1'b1;
				OP_BIT: begin
					sda_n   = shift_n[7];
					shift_n = {shift_n[6:0], 1'b0};
				end
				OP_SAMP: shift_n = {shift_n[6:0], item.sda_in};
				OP_DLY: begin
					if (wait_sum < {1'b0, dly_eff}) begin
						wait_n    = wait_sum[15:0];
						step_done = 1'b0;
					end else begin
						wait_n = '0;
					end
				end
				default: step_done = 1'b1;
			endcase

			// Advance within the block, then the bit loop, then the program
			if (step_done) begin
				if ({1'b0, op_idx} + 4'd1 < {1'b0, cur_len}) begin
					op_n = op_idx + 3'd1;
				end else begin
					op_n = '0;
					if ((cur_blk.kind == KIND_WBIT || cur_blk.kind == KIND_RBIT)
					    && bit_n != LAST_BIT) begin
						bit_n = bit_n + 3'd1;
					end else begin
						bit_n = '0;
						if (blk_inc >= prog_len) begin
							if (req_n.action)
								hold_n = shift_n;
							busy_n = 1'b0;
							done   = 1'b1;
						end else begin
							blk_n   = blk_inc;
							nxt_blk = prog_block(req_n.action, blk_inc);
							if (nxt_blk.kind == KIND_WBIT) begin
								unique case (nxt_blk.sel)
									SEL_ID:   shift_n = req_n.device_id;
									SEL_ADDR: shift_n = req_n.reg_addr;
									SEL_DATA: shift_n = req_n.write_data;
									SEL_IDR:  shift_n = req_n.device_id | READ_FLAG;
									default:  shift_n = shift_n;
								endcase
							end
						end
					end
				end
			end
		end
	end

	// Commit state on every processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			blk_q   <= '0;
			op_q    <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			wait_q  <= '0;
			req_q   <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			en_q    <= 1'b1;
			hold_q  <= '0;
		end else if (adv) begin
			busy_q  <= busy_n;
			blk_q   <= blk_n;
			op_q    <= op_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			wait_q  <= wait_n;
			req_q   <= req_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			en_q    <= en_n;
			hold_q  <= hold_n;
		end
	end

	assign res = '{scl_n, sda_n, en_n, busy_n, done, hold_n};

	// Checks
	a_done_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		adv && done |=> !busy_q)
		else $error("busy still set after transaction end");

	a_idle_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !busy_q && !item.cmd_valid |=> !busy_q)
		else $error("sequencer left idle without a command");

	a_wait_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, wait_q} < {1'b0, dly_eff}) || $changed(delay_ticks))
		else $error("delay counter beyond configured delay");

endmodule

// ===== sv/i2c_register_access_master.sv =====
`timescale 1ns / 1ps

// Single-register I2C master, stepped one bus tick per command beat.
// Channels:
//   cmd - one beat per tick: cmd_valid starts a write (action 0) or read
//         (action 1) when idle; sda_in is the sampled SDA level.
//   res - one beat per command beat: SCL/SDA levels, SDA enable, busy,
//         a done pulse on the ending tick and the last byte read.
//   cfg - writes delay_ticks, the idle ticks per bus timing delay
//         (0 counts as 1). Always ready; write only while idle.
// An accepted command beat is held in the input stage until the sequencer
// advances, which registers its result in the result stage.
// Throughput: one beat per cycle while res is ready; the sequencer update is
// a single pass of logic between the input stage and the result register.
// A stalled res channel holds its result; cmd keeps accepting until the
// input stage is also full, then ready drops until res drains.
// Reset: idle, SCL high, SDA high and driven, read byte zero, delay 256.
module i2c_register_access_master (
	input  logic clk,
	input  logic arst_n,
	i2cram_cmd_if.sink   cmd,
	i2cram_res_if.source res,
	i2cram_cfg_if.sink   cfg
);
	import i2cram_pkg::*;

	logic         valid_s1;
	i2cram_item_t item_s1;
	logic         valid_s2;
	i2cram_res_t  res_s2;
	i2cram_res_t  res_comb;
	logic [15:0]  delay_q;
	logic         adv;
	logic         take;

	assign adv  = valid_s1 && (!valid_s2 || res.ready);
	assign take = cmd.valid && cmd.ready;

	assign cmd.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// Hold the delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg.valid && cfg.ready) begin
			delay_q <= cfg.delay_ticks;
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{cmd.cmd_valid, cmd.action, cmd.device_id, cmd.reg_addr,
			             cmd.write_data, cmd.sda_in};
		end
	end

	i2cram_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item        (item_s1),
		.delay_ticks (delay_q),
		.res         (res_comb)
	);

	// Result stage valid: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_comb;
		end
	end

	assign res.valid      = valid_s2;
	assign res.scl_level  = res_s2.scl_level;
	assign res.sda_level  = res_s2.sda_level;
	assign res.sda_enable = res_s2.sda_enable;
	assign res.busy_res   = res_s2.busy_res;
	assign res.done_res   = res_s2.done_res;
	assign res.read_byte  = res_s2.read_byte;

	// Checks
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res |-> !res_s2.busy_res)
		else $error("done reported while still busy");

	a_adv_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("result stage not loaded after advance");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled beat");

endmodule
